/* hdl/tcc_pkg.sv */
// Shared types, constants and cursor-step functions for the text console cursor.
package tcc_pkg;

    // Character codes with special meaning
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_SPACE     = 8'd32;

    // Reset values of the configuration registers
    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd25;

    // Operation carried in tuser
    typedef enum logic {
        FUNC_PUT  = 1'b0,
        FUNC_MOVE = 1'b1
    } func_t;

    // Configuration register index (paddr[2])
    typedef enum logic {
        REG_COLUMNS = 1'b0,
        REG_ROWS    = 1'b1
    } reg_idx_t;

    localparam int PADDR_W  = 3;
    localparam int S_DATA_W = 24;
    localparam int M_DATA_W = 48;

    typedef struct packed {
        logic [7:0] row;
        logic [7:0] col;
    } pos_t;

    typedef struct packed {
        pos_t pos;
        logic scroll;
    } adv_t;

    // One result item
    typedef struct packed {
        logic       write_valid;
        logic [7:0] write_char;
        logic [7:0] write_row;
        logic [7:0] write_col;
        logic       scroll_up;
        logic [7:0] row_after;
        logic [7:0] col_after;
    } result_t;

    // Move back one cell, wrapping to the last column of the row above
    function automatic pos_t step_back(pos_t p, logic [7:0] cols);
        pos_t r;
        if (p.col == 8'd0) begin
            r.row = p.row - 8'd1;
            r.col = cols - 8'd1;
        end else begin
            r.row = p.row;
            r.col = p.col - 8'd1;
        end
        return r;
    endfunction

    // Column 0 and down one row, or a scroll request on the last row
    function automatic adv_t next_line(pos_t p, logic [7:0] rows);
        adv_t r;
        r.pos.col = 8'd0;
        if (rows != 8'd0 && p.row == rows - 8'd1) begin
            r.pos.row = p.row;
            r.scroll  = 1'b1;
        end else begin
            r.pos.row = p.row + 8'd1;
            r.scroll  = 1'b0;
        end
        return r;
    endfunction

    // Advance after a cell write, wrapping at the screen width
    function automatic adv_t advance(pos_t p, logic [7:0] cols, logic [7:0] rows);
        adv_t r;
        if ({1'b0, p.col} + 9'd1 >= {1'b0, cols}) begin
            r = next_line(p, rows);
        end else begin
            r.pos.row = p.row;
            r.pos.col = p.col + 8'd1;
            r.scroll  = 1'b0;
        end
        return r;
    endfunction

endpackage

/* hdl/text_console_cursor.sv */
// Text console cursor controller: cursor state, APB registers and output skid stage.
// The cursor update is one pass of compare/increment logic; each result is registered.
// Throughput: one item per cycle while the skid register is empty (s_tready high).
// A two-entry output stage (register plus skid) keeps s_tready independent of m_tready.
// Reset (aresetn low, synchronous): cursor at row 0 column 0, 80 columns, 25 rows,
// output stage empty.
module text_console_cursor (
    input  logic                          aclk,
    input  logic                          aresetn,
    // APB configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [tcc_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    // Input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [7:0] char_code, [15:8] new_row, [23:16] new_col
    input  logic [tcc_pkg::S_DATA_W-1:0]  s_tdata,
    // [0] func
    input  logic                          s_tuser,
    // Result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] write_char, [15:8] write_row, [23:16] write_col, [24] scroll_up,
    // [32:25] row_after, [40:33] col_after, [47:41] zero
    output logic [tcc_pkg::M_DATA_W-1:0]  m_tdata,
    // [0] write_valid
    output logic                          m_tuser
);
    import tcc_pkg::*;

    logic [7:0] cols_reg;
    logic [7:0] rows_reg;
    pos_t       cur_reg;
    pos_t       cur_next;
    result_t    res_next;
    result_t    out_reg;
    result_t    skid_reg;
    logic       out_valid_reg;
    logic       skid_valid_reg;
    logic       accept;
    logic       take;
    logic       cfg_wr;

    logic [7:0] in_char;
    logic [7:0] in_row;
    logic [7:0] in_col;
    func_t      in_func;

    pos_t       bs_back;
    adv_t       put_adv;
    adv_t       bs_adv;
    adv_t       nl_adv;
    pos_t       bs_end;

    // Register access
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        prdata = 32'd0;
        unique case (reg_idx_t'(paddr[2]))
            REG_COLUMNS: prdata = {24'd0, cols_reg};
            REG_ROWS:    prdata = {24'd0, rows_reg};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cols_reg <= COLS_RESET;
            rows_reg <= ROWS_RESET;
        end else if (cfg_wr) begin
            unique case (reg_idx_t'(paddr[2]))
                REG_COLUMNS: cols_reg <= pwdata[7:0];
                REG_ROWS:    rows_reg <= pwdata[7:0];
            endcase
        end
    end

    // Input field unpacking
    assign in_char = s_tdata[7:0];
    assign in_row  = s_tdata[15:8];
    assign in_col  = s_tdata[23:16];
    assign in_func = func_t'(s_tuser);

    // Candidate cursor steps
    assign put_adv = advance(cur_reg, cols_reg, rows_reg);
    assign nl_adv  = next_line(cur_reg, rows_reg);
    assign bs_back = step_back(cur_reg, cols_reg);
    assign bs_adv  = advance(bs_back, cols_reg, rows_reg);
    assign bs_end  = step_back(bs_adv.pos, cols_reg);

    // Select the result and the next cursor for this item
    always_comb begin
        res_next = '0;
        cur_next = cur_reg;
        if (in_func == FUNC_MOVE) begin
            cur_next.row = in_row;
            cur_next.col = in_col;
        end else if (in_char == CHAR_NEWLINE) begin
            cur_next           = nl_adv.pos;
            res_next.scroll_up = nl_adv.scroll;
        end else if (in_char == CHAR_BACKSPACE) begin
            // nothing happens at the origin
            if (cur_reg.row != 8'd0 || cur_reg.col != 8'd0) begin
                res_next.write_valid = 1'b1;
                res_next.write_char  = CHAR_SPACE;
                res_next.write_row   = bs_back.row;
                res_next.write_col   = bs_back.col;
                res_next.scroll_up   = bs_adv.scroll;
                cur_next             = bs_end;
            end
        end else begin
            res_next.write_valid = 1'b1;
            res_next.write_char  = in_char;
            res_next.write_row   = cur_reg.row;
            res_next.write_col   = cur_reg.col;
            res_next.scroll_up   = put_adv.scroll;
            cur_next             = put_adv.pos;
        end
        res_next.row_after = cur_next.row;
        res_next.col_after = cur_next.col;
    end

    // Handshakes
    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign take     = out_valid_reg & m_tready;

    // Cursor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg <= '0;
        end else if (accept) begin
            cur_reg <= cur_next;
        end
    end

    // Output register and skid stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (take) begin
                out_reg        <= skid_reg;
                skid_valid_reg <= 1'b0;
            end
        end else if (accept) begin
            if (!out_valid_reg || take) begin
                out_reg       <= res_next;
                out_valid_reg <= 1'b1;
            end else begin
                skid_reg       <= res_next;
                skid_valid_reg <= 1'b1;
            end
        end else if (take) begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result packing
    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.write_valid;
    assign m_tdata  = {7'd0, out_reg.col_after, out_reg.row_after, out_reg.scroll_up,
                       out_reg.write_col, out_reg.write_row, out_reg.write_char};

endmodule

/* test/text_console_cursor_tb.sv */
// Self-checking testbench for the text console cursor: directed cases, random streams, back-pressure.
module text_console_cursor_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tcc_pkg::*;

    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_OFF_LEN  = 200;

    logic                aclk;
    logic                aresetn;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    logic                s_tvalid;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata;   // [7:0] char_code, [15:8] new_row, [23:16] new_col
    logic                s_tuser;   // [0] func
    logic                m_tvalid;
    logic                m_tready;
    logic [M_DATA_W-1:0] m_tdata;   // [7:0] write_char, [15:8] write_row, [23:16] write_col,
                                    // [24] scroll_up, [32:25] row_after, [40:33] col_after
    logic                m_tuser;   // [0] write_valid

    text_console_cursor DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // Shadow copy of the cursor and screen size
    logic [7:0] shadow_row;
    logic [7:0] shadow_col;
    logic [7:0] screen_cols;
    logic [7:0] screen_rows;

    result_t    pending_results[$];
    int         error_count;
    int         cycle_count;
    int         sender_idle_pct;
    int         receiver_stall_pct;
    int         hold_off_left;

    // Clock
    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Cycle limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Cursor prediction

    // Column 0, then down a row or a scroll request on the last row
    function automatic logic line_feed();
        shadow_col = 8'd0;
        if (screen_rows != 8'd0 && shadow_row == screen_rows - 8'd1)
            return 1'b1;
        shadow_row = shadow_row + 8'd1;
        return 1'b0;
    endfunction

    // One cell back, wrapping to the last column of the row above
    function automatic void cell_back();
        if (shadow_col == 8'd0) begin
            shadow_row = shadow_row - 8'd1;
            shadow_col = screen_cols - 8'd1;
        end else begin
            shadow_col = shadow_col - 8'd1;
        end
    endfunction

    // Cell write at the cursor, then advance with wrap at the screen width
    function automatic result_t cell_write(logic [7:0] ch);
        result_t r;
        r             = '0;
        r.write_valid = 1'b1;
        r.write_char  = ch;
        r.write_row   = shadow_row;
        r.write_col   = shadow_col;
        if ({1'b0, shadow_col} + 9'd1 >= {1'b0, screen_cols})
            r.scroll_up = line_feed();
        else
            shadow_col = shadow_col + 8'd1;
        return r;
    endfunction

    function automatic result_t cursor_predict(func_t f, logic [7:0] ch,
                                               logic [7:0] nr, logic [7:0] nc);
        result_t r;
        r = '0;
        if (f == FUNC_MOVE) begin
            shadow_row = nr;
            shadow_col = nc;
        end else if (ch == CHAR_NEWLINE) begin
            r.scroll_up = line_feed();
        end else if (ch == CHAR_BACKSPACE) begin
            // nothing to erase at the origin
            if (!(shadow_row == 8'd0 && shadow_col == 8'd0)) begin
                cell_back();
                r = cell_write(CHAR_SPACE);
                cell_back();
            end
        end else begin
            r = cell_write(ch);
        end
        r.row_after = shadow_row;
        r.col_after = shadow_col;
        return r;
    endfunction

    // Predict on every accepted input transfer
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            pending_results.push_back(cursor_predict(func_t'(s_tuser), s_tdata[7:0],
                                                     s_tdata[15:8], s_tdata[23:16]));
    end

    // ------------------------------------------------------------------
    // Result checking

    function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual tdata %h tuser %b",
                         $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                check_field("write_valid", {7'd0, want.write_valid}, {7'd0, m_tuser});
                check_field("write_char",  want.write_char,  m_tdata[7:0]);
                check_field("write_row",   want.write_row,   m_tdata[15:8]);
                check_field("write_col",   want.write_col,   m_tdata[23:16]);
                check_field("scroll_up",   {7'd0, want.scroll_up}, {7'd0, m_tdata[24]});
                check_field("row_after",   want.row_after,   m_tdata[32:25]);
                check_field("col_after",   want.col_after,   m_tdata[40:33]);
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_off_left > 0) begin
            m_tready <= 1'b0;
            hold_off_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Drivers

    task automatic reg_write(reg_idx_t idx, logic [7:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        // register takes the value at this edge
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_COLUMNS)
            screen_cols = value;
        else
            screen_rows = value;
    endtask

    // One item; tvalid stays high on return so back-to-back transfers need no gap
    task automatic send_item(func_t f, logic [7:0] ch, logic [7:0] nr, logic [7:0] nc);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {nc, nr, ch};
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic put_char(logic [7:0] ch);
        send_item(FUNC_PUT, ch, 8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic move_to(logic [7:0] nr, logic [7:0] nc);
        send_item(FUNC_MOVE, 8'($urandom_range(255)), nr, nc);
    endtask

    // Wait for every outstanding result, then a short pause
    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge aclk);
        repeat (3) @(posedge aclk);
    endtask

    task automatic set_screen(logic [7:0] cols, logic [7:0] rows);
        reg_write(REG_COLUMNS, cols);
        reg_write(REG_ROWS, rows);
    endtask

    // Mostly text with line breaks and erases; some moves on and off the screen
    task automatic send_random_item();
        int pick;
        int row_max;
        int col_max;
        pick    = $urandom_range(99);
        row_max = (screen_rows == 8'd0) ? 255 : screen_rows - 1;
        col_max = (screen_cols == 8'd0) ? 255 : screen_cols - 1;
        if (pick < 58)
            put_char(8'($urandom_range(255)));
        else if (pick < 70)
            put_char(CHAR_NEWLINE);
        else if (pick < 86)
            put_char(CHAR_BACKSPACE);
        else if (pick < 94)
            move_to(8'($urandom_range(row_max)), 8'($urandom_range(col_max)));
        else
            move_to(8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    // ------------------------------------------------------------------
    // Tests

    task automatic test_default_screen();
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        put_char(8'h41);                  // origin write
        put_char(CHAR_BACKSPACE);         // erase back to origin
        put_char(CHAR_BACKSPACE);         // at origin: no change
        put_char(8'hFF);
        put_char(8'h00);
        put_char(CHAR_NEWLINE);
        put_char(CHAR_BACKSPACE);         // wraps back across the line
        move_to(8'd24, 8'd79);
        put_char(8'h5A);                  // last cell: scroll
        move_to(8'd24, 8'd0);
        put_char(CHAR_NEWLINE);           // newline on last row: scroll
        move_to(8'd25, 8'd0);
        put_char(CHAR_BACKSPACE);         // erase with scroll
        move_to(8'd255, 8'd255);
        put_char(8'h7E);                  // beyond screen: wrap and row wrap
        move_to(8'd255, 8'd0);
        put_char(CHAR_NEWLINE);
        move_to(8'd0, 8'd200);
        put_char(8'h20);
        move_to(8'd0, 8'd1);
        put_char(CHAR_BACKSPACE);
        move_to(8'hAA, 8'h55);
        move_to(8'h55, 8'hAA);
        move_to(8'd0, 8'd0);
        put_char(CHAR_BACKSPACE);
        drain();
    endtask

    task automatic test_zero_registers();
        set_screen(8'd0, 8'd0);
        move_to(8'd0, 8'd0);
        put_char(8'h78);                  // wraps at once
        put_char(CHAR_BACKSPACE);         // last column becomes 255
        put_char(CHAR_NEWLINE);           // no last row: never scrolls
        move_to(8'd255, 8'd0);
        put_char(CHAR_NEWLINE);
        drain();
    endtask

    task automatic test_random_phase(logic [7:0] cols, logic [7:0] rows, int count,
                                     int idle_pct, int stall_pct);
        set_screen(cols, rows);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (count) send_random_item();
        drain();
    endtask

    // Receiver holds off while items keep coming, so the block fills and stalls its input
    task automatic test_backpressure();
        set_screen(8'd5, 8'd4);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = HOLD_OFF_LEN;
        repeat (100) send_random_item();
        drain();
    endtask

    // ------------------------------------------------------------------
    // Main sequence

    initial begin
        aresetn            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        s_tvalid           = 1'b0;
        s_tdata            = '0;
        s_tuser            = 1'b0;
        m_tready           = 1'b0;
        error_count        = 0;
        cycle_count        = 0;
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        hold_off_left      = 0;
        shadow_row         = 8'd0;
        shadow_col         = 8'd0;
        screen_cols        = COLS_RESET;
        screen_rows        = ROWS_RESET;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_default_screen();
        test_zero_registers();
        test_random_phase(8'd80,  8'd25,  150, 0,  0);
        test_random_phase(8'd1,   8'd1,   150, 71, 0);
        test_random_phase(8'd255, 8'd255, 150, 0,  71);
        test_random_phase(8'd0,   8'd0,   120, 16, 16);
        test_random_phase(8'd7,   8'd3,   150, 16, 16);
        test_random_phase(8'd255, 8'd1,   120, 0,  0);
        test_random_phase(8'd1,   8'd255, 120, 71, 0);
        test_random_phase(8'($urandom_range(1, 255)), 8'($urandom_range(1, 255)),
                          150, 0, 71);
        test_backpressure();

        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
